// File: hw/rtl/differential_drive_pd_move_unit_macros.svh
// Assertion macros shared by the drive move unit.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef DIFFERENTIAL_DRIVE_PD_MOVE_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_PD_MOVE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// cond implies prop in the same cycle
`define DDPM_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("ddpm assertion failed");
// cond implies prop in the next cycle
`define DDPM_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("ddpm assertion failed");
`else
`define DDPM_ASSERT_SAME(label, cond, prop)
`define DDPM_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// File: hw/rtl/ddpm_pkg.sv
`timescale 1ns / 1ps

package ddpm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 11;
  localparam int TARGET_W   = 24;
  localparam int BIAS_W     = 16;
  localparam int GAIN_W     = 24;
  localparam int MAXSPD_W   = 8;
  localparam int POWER_W    = MAXSPD_W + 1;
  localparam int THR_W      = 16;
  localparam int TMO_W      = 16;
  localparam int FRAC_BITS  = 17;
  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_MODE,
    REG_ACCEPT_WITHOUT_DWELL,
    REG_PROP_GAIN,
    REG_DERIV_GAIN,
    REG_SIDE_GAIN,
    REG_MAX_SPEED,
    REG_SETTLE_THRESHOLD,
    REG_TIMEOUT_MS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CAUSE_RUNNING,
    CAUSE_REACHED,
    CAUSE_STALLED,
    CAUSE_TIMEOUT
  } exit_cause_t;

  typedef struct packed {
    logic                turn_mode;
    logic                accept_without_dwell;
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [GAIN_W-1:0]   side_gain;
    logic [MAXSPD_W-1:0] max_speed;
    logic [THR_W-1:0]    settle_threshold;
    logic [TMO_W-1:0]    timeout_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    turn_mode:            1'b0,
    accept_without_dwell: 1'b0,
    prop_gain:            24'd13107,
    deriv_gain:           24'd98,
    side_gain:            24'd0,
    max_speed:            8'd100,
    settle_threshold:     16'd25,
    timeout_ms:           16'd0
  };

  // Status that travels with each transaction from classification to output
  typedef struct packed {
    logic        zero_power;
    logic        move_done;
    exit_cause_t exit_cause;
  } ctl_t;

  // Doubled error width: holds 2*target - (dr +- dl) + 2*bias without overflow
  function automatic int err_width(input int pos_bits);
    return ((pos_bits > TARGET_W) ? pos_bits : TARGET_W) + 3;
  endfunction

endpackage

// File: hw/rtl/ddpm_queue.sv
`timescale 1ns / 1ps
`include "differential_drive_pd_move_unit_macros.svh"

module ddpm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `DDPM_ASSERT_SAME(a_q_no_overflow, push, !full || pop)
  `DDPM_ASSERT_SAME(a_q_no_underflow, pop, pop_valid)
  `DDPM_ASSERT_SAME(a_q_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))

endmodule

// File: hw/rtl/ddpm_front.sv
`timescale 1ns / 1ps
`include "differential_drive_pd_move_unit_macros.svh"

module ddpm_front #(
  parameter int POSITION_BITS   = 24,
  parameter int SETTLE_DWELL_MS = 250,
  parameter int STALL_DWELL_MS  = 1000,
  parameter int STALL_SPEED     = 50,
  localparam int DELTA_W = POSITION_BITS + 1,
  localparam int SIDE_W  = POSITION_BITS + 2,
  localparam int E_W     = ddpm_pkg::err_width(POSITION_BITS),
  localparam int V_W     = ddpm_pkg::SPEED_W + 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ddpm_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_kind,
  input  logic [ddpm_pkg::TIME_W-1:0]         in_time_ms,
  input  logic signed [POSITION_BITS-1:0]     in_right_position,
  input  logic signed [POSITION_BITS-1:0]     in_left_position,
  input  logic signed [ddpm_pkg::SPEED_W-1:0] in_right_speed,
  input  logic signed [ddpm_pkg::SPEED_W-1:0] in_left_speed,
  input  logic signed [ddpm_pkg::TARGET_W-1:0] in_target_distance,
  input  logic signed [ddpm_pkg::BIAS_W-1:0]  in_overshoot_bias,
  input  logic                                q_full,
  output logic                                q_push,
  output ddpm_pkg::ctl_t                      q_ctl,
  output logic signed [E_W-1:0]               q_ea2,
  output logic signed [V_W-1:0]               q_v2,
  output logic signed [SIDE_W-1:0]            q_side
);

  import ddpm_pkg::*;

  localparam logic [TIME_W-1:0] SETTLE_LIM = TIME_W'(SETTLE_DWELL_MS);
  localparam logic [TIME_W-1:0] STALL_LIM  = TIME_W'(STALL_DWELL_MS);
  localparam logic [V_W-1:0]    SPEED_LIM  = V_W'(STALL_SPEED);

  logic en;

  // move context captured by a start transaction
  logic signed [POSITION_BITS-1:0] start_right_r;
  logic signed [POSITION_BITS-1:0] start_left_r;
  logic [TIME_W-1:0]               move_t0_r;
  logic signed [TARGET_W-1:0]      target_r;
  logic signed [BIAS_W-1:0]        bias_r;

  // stage A: position deltas
  logic                        a_v_r;
  logic                        a_kind_r;
  logic [TIME_W-1:0]           a_time_r;
  logic [TIME_W-1:0]           a_t0_r;
  logic signed [DELTA_W-1:0]   a_dr_r;
  logic signed [DELTA_W-1:0]   a_dl_r;
  logic signed [SPEED_W-1:0]   a_rs_r;
  logic signed [SPEED_W-1:0]   a_ls_r;
  logic signed [TARGET_W-1:0]  a_tgt_r;
  logic signed [BIAS_W-1:0]    a_bias_r;
  logic signed [DELTA_W-1:0]   dr_nxt;
  logic signed [DELTA_W-1:0]   dl_nxt;

  // stage B: doubled error, speed sum, side difference (speed difference and side sum in turn mode)
  logic signed [E_W-1:0]       t2;
  logic signed [E_W-1:0]       drx;
  logic signed [E_W-1:0]       dlx;
  logic signed [SIDE_W-1:0]    sdr;
  logic signed [SIDE_W-1:0]    sdl;
  logic signed [V_W-1:0]       rs_ext;
  logic signed [V_W-1:0]       ls_ext;
  logic [V_W-1:0]              rs_mag;
  logic [V_W-1:0]              ls_mag;
  logic signed [E_W-1:0]       e2_nxt;
  logic signed [V_W-1:0]       v2_nxt;
  logic signed [SIDE_W-1:0]    side_nxt;

  // stage C: thresholds, timers and classification
  logic                        c_v_r;
  logic                        c_kind_r;
  logic [TIME_W-1:0]           c_time_r;
  logic [TIME_W-1:0]           c_t0_r;
  logic signed [E_W-1:0]       c_e2_r;
  logic signed [V_W-1:0]       c_v2_r;
  logic signed [SIDE_W-1:0]    c_side_r;
  logic signed [BIAS_W-1:0]    c_bias_r;
  logic                        c_slow_r;
  logic                        c_fast_r;

  logic                        b_v_r;
  logic                        b_kind_r;
  logic [TIME_W-1:0]           b_time_r;
  logic [TIME_W-1:0]           b_t0_r;
  logic signed [BIAS_W-1:0]    b_bias_r;
  logic signed [E_W-1:0]       b_e2_r;
  logic signed [V_W-1:0]       b_v2_r;
  logic signed [SIDE_W-1:0]    b_side_r;
  logic                        b_slow_r;
  logic                        b_fast_r;

  logic                        settle_armed_r;
  logic [TIME_W-1:0]           settle_since_r;
  logic                        stall_armed_r;
  logic [TIME_W-1:0]           stall_since_r;
  logic                        stall_latched_r;
  logic                        timeout_latched_r;

  logic                        e_neg;
  logic [E_W-1:0]              abs_e2;
  logic                        in_thr;
  logic signed [E_W-1:0]       bias2;
  logic                        settle_armed_nxt;
  logic [TIME_W-1:0]           settle_since_nxt;
  logic                        stall_armed_nxt;
  logic [TIME_W-1:0]           stall_since_nxt;
  logic [TIME_W-1:0]           settle_el;
  logic [TIME_W-1:0]           stall_el;
  logic [TIME_W-1:0]           move_el;
  logic                        reached;
  logic                        stalled;
  logic                        timed;
  logic                        latched;
  exit_cause_t                 cause;
  logic                        smp_push;
  logic                        start_push;

  // the whole front advances together; it holds only when stage C cannot push
  assign en       = !c_v_r || !q_full;
  assign in_ready = en;
  assign q_push   = c_v_r && en;

  assign smp_push   = q_push && (c_kind_r == KIND_SAMPLE);
  assign start_push = q_push && (c_kind_r == KIND_START);

  assign dr_nxt = {in_right_position[POSITION_BITS-1], in_right_position}
                - {start_right_r[POSITION_BITS-1], start_right_r};
  assign dl_nxt = {in_left_position[POSITION_BITS-1], in_left_position}
                - {start_left_r[POSITION_BITS-1], start_left_r};

  always_comb begin
    t2     = {{(E_W-TARGET_W-1){a_tgt_r[TARGET_W-1]}}, a_tgt_r, 1'b0};
    drx    = {{(E_W-DELTA_W){a_dr_r[DELTA_W-1]}}, a_dr_r};
    dlx    = {{(E_W-DELTA_W){a_dl_r[DELTA_W-1]}}, a_dl_r};
    sdr    = {a_dr_r[DELTA_W-1], a_dr_r};
    sdl    = {a_dl_r[DELTA_W-1], a_dl_r};
    rs_ext = {a_rs_r[SPEED_W-1], a_rs_r};
    ls_ext = {a_ls_r[SPEED_W-1], a_ls_r};
    rs_mag = a_rs_r[SPEED_W-1] ? -rs_ext : rs_ext;
    ls_mag = a_ls_r[SPEED_W-1] ? -ls_ext : ls_ext;
    if (cfg.turn_mode) begin
      e2_nxt   = t2 - drx + dlx;
      v2_nxt   = rs_ext - ls_ext;
      side_nxt = sdr + sdl;
    end else begin
      e2_nxt   = t2 - drx - dlx;
      v2_nxt   = rs_ext + ls_ext;
      side_nxt = sdr - sdl;
    end
  end

  always_comb begin
    e_neg  = c_e2_r[E_W-1];
    abs_e2 = e_neg ? -c_e2_r : c_e2_r;
    in_thr = abs_e2 <= E_W'({cfg.settle_threshold, 1'b0});
    bias2  = {{(E_W-BIAS_W-1){c_bias_r[BIAS_W-1]}}, c_bias_r, 1'b0};
    q_ea2  = e_neg ? c_e2_r - bias2 : c_e2_r + bias2;
    q_v2   = c_v2_r;
    q_side = c_side_r;

    settle_armed_nxt = in_thr;
    settle_since_nxt = (in_thr && !settle_armed_r) ? c_time_r : settle_since_r;
    stall_armed_nxt  = c_fast_r ? 1'b0 : (c_slow_r ? 1'b1 : stall_armed_r);
    stall_since_nxt  = (c_slow_r && !stall_armed_r) ? c_time_r : stall_since_r;

    settle_el = c_time_r - settle_since_r;
    stall_el  = c_time_r - stall_since_r;
    move_el   = c_time_r - c_t0_r;

    // a timer armed on this very sample has zero elapsed time
    reached = in_thr && (cfg.accept_without_dwell || (settle_armed_r && settle_el > SETTLE_LIM));
    stalled = stall_armed_nxt && stall_armed_r && (stall_el > STALL_LIM);
    timed   = (cfg.timeout_ms != '0) && (move_el > TIME_W'(cfg.timeout_ms));
    latched = stall_latched_r || timeout_latched_r;

    if (stalled) begin
      cause = CAUSE_STALLED;
    end else if (timed) begin
      cause = CAUSE_TIMEOUT;
    end else if (reached) begin
      cause = CAUSE_REACHED;
    end else begin
      cause = CAUSE_RUNNING;
    end

    if (c_kind_r == KIND_START) begin
      q_ctl.zero_power = 1'b1;
      q_ctl.move_done  = 1'b0;
      q_ctl.exit_cause = CAUSE_RUNNING;
    end else if (latched) begin
      q_ctl.zero_power = 1'b1;
      q_ctl.move_done  = 1'b1;
      q_ctl.exit_cause = stall_latched_r ? CAUSE_STALLED : CAUSE_TIMEOUT;
    end else begin
      q_ctl.zero_power = 1'b0;
      q_ctl.move_done  = (cause != CAUSE_RUNNING);
      q_ctl.exit_cause = cause;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r         <= 1'b0;
      b_v_r         <= 1'b0;
      c_v_r         <= 1'b0;
      start_right_r <= '0;
      start_left_r  <= '0;
      move_t0_r     <= '0;
      target_r      <= '0;
      bias_r        <= '0;
    end else begin
      if (en) begin
        a_v_r <= in_valid;
        b_v_r <= a_v_r;
        c_v_r <= b_v_r;
      end
      if (in_valid && en && in_kind == KIND_START) begin
        start_right_r <= in_right_position;
        start_left_r  <= in_left_position;
        move_t0_r     <= in_time_ms;
        target_r      <= in_target_distance;
        bias_r        <= in_overshoot_bias;
      end
    end
  end

  // payload stages; a sample carries the move context it was accepted under
  always_ff @(posedge clk) begin
    if (en) begin
      a_kind_r <= in_kind;
      a_time_r <= in_time_ms;
      a_t0_r   <= move_t0_r;
      a_dr_r   <= dr_nxt;
      a_dl_r   <= dl_nxt;
      a_rs_r   <= in_right_speed;
      a_ls_r   <= in_left_speed;
      a_tgt_r  <= target_r;
      a_bias_r <= bias_r;

      b_kind_r <= a_kind_r;
      b_time_r <= a_time_r;
      b_t0_r   <= a_t0_r;
      b_bias_r <= a_bias_r;
      b_e2_r   <= e2_nxt;
      b_v2_r   <= v2_nxt;
      b_side_r <= side_nxt;
      b_slow_r <= (rs_mag < SPEED_LIM) && (ls_mag < SPEED_LIM);
      b_fast_r <= (rs_mag > SPEED_LIM) || (ls_mag > SPEED_LIM);

      c_kind_r <= b_kind_r;
      c_time_r <= b_time_r;
      c_t0_r   <= b_t0_r;
      c_bias_r <= b_bias_r;
      c_e2_r   <= b_e2_r;
      c_v2_r   <= b_v2_r;
      c_side_r <= b_side_r;
      c_slow_r <= b_slow_r;
      c_fast_r <= b_fast_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_armed_r    <= 1'b0;
      settle_since_r    <= '0;
      stall_armed_r     <= 1'b0;
      stall_since_r     <= '0;
      stall_latched_r   <= 1'b0;
      timeout_latched_r <= 1'b0;
    end else if (q_push) begin
      if (c_kind_r == KIND_START) begin
        settle_armed_r    <= 1'b0;
        settle_since_r    <= '0;
        stall_armed_r     <= 1'b0;
        stall_since_r     <= '0;
        stall_latched_r   <= 1'b0;
        timeout_latched_r <= 1'b0;
      end else if (!latched) begin
        settle_armed_r <= settle_armed_nxt;
        settle_since_r <= settle_since_nxt;
        stall_armed_r  <= stall_armed_nxt;
        stall_since_r  <= stall_since_nxt;
        if (stalled) begin
          stall_latched_r <= 1'b1;
        end
        if (timed) begin
          timeout_latched_r <= 1'b1;
        end
      end
    end
  end

  `DDPM_ASSERT_NEXT(a_stall_latches, smp_push && !latched && stalled, stall_latched_r)
  `DDPM_ASSERT_SAME(a_latched_stop, smp_push && latched, q_ctl.zero_power && q_ctl.move_done)
  `DDPM_ASSERT_NEXT(a_start_clears, start_push, !latched && !settle_armed_r)

endmodule

// File: hw/rtl/ddpm_back.sv
`timescale 1ns / 1ps

module ddpm_back #(
  parameter int POSITION_BITS = 24,
  localparam int SIDE_W = POSITION_BITS + 2,
  localparam int E_W    = ddpm_pkg::err_width(POSITION_BITS),
  localparam int V_W    = ddpm_pkg::SPEED_W + 1,
  localparam int PE_W   = E_W + ddpm_pkg::GAIN_W + 1,
  localparam int PV_W   = V_W + ddpm_pkg::GAIN_W + 1,
  localparam int PS_W   = SIDE_W + ddpm_pkg::GAIN_W + 1,
  localparam int SUM_W  = E_W + ddpm_pkg::GAIN_W + 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ddpm_pkg::cfg_t                      cfg,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  ddpm_pkg::ctl_t                      q_ctl,
  input  logic signed [E_W-1:0]               q_ea2,
  input  logic signed [V_W-1:0]               q_v2,
  input  logic signed [SIDE_W-1:0]            q_side,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ddpm_pkg::POWER_W-1:0] out_right_power,
  output logic signed [ddpm_pkg::POWER_W-1:0] out_left_power,
  output logic                                out_move_done,
  output logic [1:0]                          out_exit_cause
);

  import ddpm_pkg::*;

  // truncate toward zero from 2^-17 units, then clamp to +-lim
  function automatic logic signed [POWER_W-1:0] to_power(
    input logic signed [SUM_W-1:0] v,
    input logic [MAXSPD_W-1:0]     lim
  );
    logic [SUM_W-1:0]           mag;
    logic [SUM_W-FRAC_BITS-1:0] hi;
    logic [MAXSPD_W-1:0]        m;
    mag = v[SUM_W-1] ? (~v + 1'b1) : v;
    hi  = mag[SUM_W-1:FRAC_BITS];
    m   = (hi > (SUM_W-FRAC_BITS)'(lim)) ? lim : hi[MAXSPD_W-1:0];
    return v[SUM_W-1] ? -{1'b0, m} : {1'b0, m};
  endfunction

  logic en;

  logic signed [PE_W-1:0]  pe_nxt;
  logic signed [PV_W-1:0]  pv_nxt;
  logic signed [PS_W-1:0]  ps_nxt;

  logic                    m_v_r;
  ctl_t                    m_ctl_r;
  logic signed [PE_W-1:0]  m_pe_r;
  logic signed [PV_W-1:0]  m_pv_r;
  logic signed [PS_W-1:0]  m_ps_r;

  logic signed [SUM_W-1:0] drive_sum;
  logic signed [SUM_W-1:0] side_sum;
  logic signed [SUM_W-1:0] right_nxt;
  logic signed [SUM_W-1:0] left_nxt;

  logic                    s_v_r;
  ctl_t                    s_ctl_r;
  logic signed [SUM_W-1:0] s_right_r;
  logic signed [SUM_W-1:0] s_left_r;

  logic                        out_valid_r;
  logic signed [POWER_W-1:0]   out_right_r;
  logic signed [POWER_W-1:0]   out_left_r;
  logic                        out_done_r;
  exit_cause_t                 out_cause_r;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = q_valid && en;

  assign pe_nxt = q_ea2 * $signed({1'b0, cfg.prop_gain});
  assign pv_nxt = q_v2 * $signed({1'b0, cfg.deriv_gain});
  assign ps_nxt = q_side * $signed({1'b0, cfg.side_gain});

  always_comb begin
    drive_sum = {{(SUM_W-PE_W){m_pe_r[PE_W-1]}}, m_pe_r}
              - {{(SUM_W-PV_W){m_pv_r[PV_W-1]}}, m_pv_r};
    side_sum  = {{(SUM_W-PS_W-1){m_ps_r[PS_W-1]}}, m_ps_r, 1'b0};
    if (cfg.turn_mode) begin
      right_nxt = drive_sum - side_sum;
      left_nxt  = side_sum - drive_sum;
    end else begin
      right_nxt = drive_sum + side_sum;
      left_nxt  = drive_sum - side_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r       <= 1'b0;
      s_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      m_v_r       <= q_valid;
      s_v_r       <= m_v_r;
      out_valid_r <= s_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ctl_r   <= q_ctl;
      m_pe_r    <= pe_nxt;
      m_pv_r    <= pv_nxt;
      m_ps_r    <= ps_nxt;
      s_ctl_r   <= m_ctl_r;
      s_right_r <= right_nxt;
      s_left_r  <= left_nxt;
      out_done_r  <= s_ctl_r.move_done;
      out_cause_r <= s_ctl_r.exit_cause;
      if (s_ctl_r.zero_power) begin
        out_right_r <= '0;
        out_left_r  <= '0;
      end else begin
        out_right_r <= to_power(s_right_r, cfg.max_speed);
        out_left_r  <= to_power(s_left_r, cfg.max_speed);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_right_power = out_right_r;
  assign out_left_power  = out_left_r;
  assign out_move_done   = out_done_r;
  assign out_exit_cause  = out_cause_r;

endmodule

// File: hw/rtl/differential_drive_pd_move_unit.sv
`timescale 1ns / 1ps
// Drive move controller: PD on the averaged side error plus a side-balance term.
// Input channel (in_valid/in_ready): kind 0 starts a move and captures positions,
// time, target and bias; kind 1 is a control sample. Every transaction yields
// exactly one result on the output channel (out_valid/out_ready) with both
// clamped powers, move_done and exit_cause, in input order.
// Path: front stages A, B and C, the queue, back stages M and S, then the output register.
// Throughput: one transaction per cycle while in_ready is high; the front classifier and the multiplier
// back end are each fully pipelined (three stages each), joined by a 4-entry queue.
// Receiver stall: the output register holds, the back end freezes, the queue
// absorbs up to 4 results, then in_ready drops until room frees up.
// Configuration: write cfg_wdata to register cfg_idx with cfg_we, only while idle.
// Reset (synchronous, rst_n low): registers return to their defaults, the move
// context and all timers and latches clear, and both pipelines empty.
// No clearing pass is needed; the block accepts transactions right after reset.

module differential_drive_pd_move_unit #(
  parameter int SETTLE_DWELL_MS = 250,
  parameter int STALL_DWELL_MS  = 1000,
  parameter int STALL_SPEED     = 50,
  parameter int POSITION_BITS   = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ddpm_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [ddpm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [ddpm_pkg::TIME_W-1:0]          in_time_ms,
  input  logic signed [POSITION_BITS-1:0]      in_right_position,
  input  logic signed [POSITION_BITS-1:0]      in_left_position,
  input  logic signed [ddpm_pkg::SPEED_W-1:0]  in_right_speed,
  input  logic signed [ddpm_pkg::SPEED_W-1:0]  in_left_speed,
  input  logic signed [ddpm_pkg::TARGET_W-1:0] in_target_distance,
  input  logic signed [ddpm_pkg::BIAS_W-1:0]   in_overshoot_bias,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ddpm_pkg::POWER_W-1:0]  out_right_power,
  output logic signed [ddpm_pkg::POWER_W-1:0]  out_left_power,
  output logic                                 out_move_done,
  output logic [1:0]                           out_exit_cause
);

  import ddpm_pkg::*;

  localparam int E_W    = err_width(POSITION_BITS);
  localparam int V_W    = SPEED_W + 1;
  localparam int SIDE_W = POSITION_BITS + 2;
  localparam int Q_W    = $bits(ctl_t) + E_W + V_W + SIDE_W;

  cfg_t cfg_r;

  logic                     push;
  logic                     q_full;
  ctl_t                     push_ctl;
  logic signed [E_W-1:0]    push_ea2;
  logic signed [V_W-1:0]    push_v2;
  logic signed [SIDE_W-1:0] push_side;

  logic                     pop;
  logic                     pop_valid;
  logic [Q_W-1:0]           pop_data;
  ctl_t                     pop_ctl;
  logic signed [E_W-1:0]    pop_ea2;
  logic signed [V_W-1:0]    pop_v2;
  logic signed [SIDE_W-1:0] pop_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_TURN_MODE:            cfg_r.turn_mode <= cfg_wdata[0];
        REG_ACCEPT_WITHOUT_DWELL: cfg_r.accept_without_dwell <= cfg_wdata[0];
        REG_PROP_GAIN:            cfg_r.prop_gain <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:           cfg_r.deriv_gain <= cfg_wdata[GAIN_W-1:0];
        REG_SIDE_GAIN:            cfg_r.side_gain <= cfg_wdata[GAIN_W-1:0];
        REG_MAX_SPEED:            cfg_r.max_speed <= cfg_wdata[MAXSPD_W-1:0];
        REG_SETTLE_THRESHOLD:     cfg_r.settle_threshold <= cfg_wdata[THR_W-1:0];
        REG_TIMEOUT_MS:           cfg_r.timeout_ms <= cfg_wdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  ddpm_front #(
    .POSITION_BITS  (POSITION_BITS),
    .SETTLE_DWELL_MS(SETTLE_DWELL_MS),
    .STALL_DWELL_MS (STALL_DWELL_MS),
    .STALL_SPEED    (STALL_SPEED)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_time_ms        (in_time_ms),
    .in_right_position (in_right_position),
    .in_left_position  (in_left_position),
    .in_right_speed    (in_right_speed),
    .in_left_speed     (in_left_speed),
    .in_target_distance(in_target_distance),
    .in_overshoot_bias (in_overshoot_bias),
    .q_full            (q_full),
    .q_push            (push),
    .q_ctl             (push_ctl),
    .q_ea2             (push_ea2),
    .q_v2              (push_v2),
    .q_side            (push_side)
  );

  ddpm_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_ctl, push_ea2, push_v2, push_side}),
    .full     (q_full),
    .pop      (pop),
    .pop_valid(pop_valid),
    .pop_data (pop_data)
  );

  assign {pop_ctl, pop_ea2, pop_v2, pop_side} = pop_data;

  ddpm_back #(
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (pop_valid),
    .q_pop          (pop),
    .q_ctl          (pop_ctl),
    .q_ea2          (pop_ea2),
    .q_v2           (pop_v2),
    .q_side         (pop_side),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_right_power(out_right_power),
    .out_left_power (out_left_power),
    .out_move_done  (out_move_done),
    .out_exit_cause (out_exit_cause)
  );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ddpm_pkg::*;

  localparam int POS_W         = 24;
  localparam int SETTLE_MS     = 250;
  localparam int STALL_MS      = 1000;
  localparam int STALL_SPD     = 50;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = 20;

  typedef struct {
    logic                       kind;
    logic [TIME_W-1:0]          stamp;
    logic signed [POS_W-1:0]    right_pos;
    logic signed [POS_W-1:0]    left_pos;
    logic signed [SPEED_W-1:0]  right_spd;
    logic signed [SPEED_W-1:0]  left_spd;
    logic signed [TARGET_W-1:0] target;
    logic signed [BIAS_W-1:0]   bias;
  } drive_item_t;

  typedef struct {
    logic signed [POWER_W-1:0] right_power;
    logic signed [POWER_W-1:0] left_power;
    logic                      done;
    exit_cause_t               cause;
  } drive_result_t;

  class drive_move_scoreboard;
    cfg_t          cfg;
    longint        org_right, org_left, goal, bias_cnt;
    logic [31:0]   move_t0, settle_t0, stall_t0;
    bit            settle_on, stall_on, stall_hit, tmo_hit;
    drive_result_t expected_results[$];
    int            errors;

    function new();
      cfg = CFG_RESET;
      org_right = 0; org_left = 0; goal = 0; bias_cnt = 0;
      move_t0 = 0; settle_t0 = 0; stall_t0 = 0;
      settle_on = 0; stall_on = 0; stall_hit = 0; tmo_hit = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Truncate toward zero from 2^-17 units, then clamp to +-max_speed.
    function longint clamp_power(longint num);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = mag >> FRAC_BITS;
      if (mag > longint'(cfg.max_speed)) mag = longint'(cfg.max_speed);
      return (num < 0) ? -mag : mag;
    endfunction

    function void note_transaction(drive_item_t it);
      longint        rp, lp, rs, ls, dr, dl, e2, v2, side, b, s, a, ae2, ars, als;
      bit            in_thr, reached, stalled, timed;
      drive_result_t want;
      rp = longint'(it.right_pos);
      lp = longint'(it.left_pos);
      rs = longint'(it.right_spd);
      ls = longint'(it.left_spd);
      want.right_power = '0;
      want.left_power  = '0;
      want.done        = 1'b0;
      want.cause       = CAUSE_RUNNING;
      if (it.kind == KIND_START) begin
        org_right = rp; org_left = lp;
        move_t0 = it.stamp;
        goal = longint'(it.target);
        bias_cnt = longint'(it.bias);
        settle_on = 0; stall_on = 0; settle_t0 = 0; stall_t0 = 0;
        stall_hit = 0; tmo_hit = 0;
      end else if (stall_hit || tmo_hit) begin
        // hold zero power until the next start
        want.done  = 1'b1;
        want.cause = stall_hit ? CAUSE_STALLED : CAUSE_TIMEOUT;
      end else begin
        dr = rp - org_right;
        dl = lp - org_left;
        if (cfg.turn_mode) begin
          e2 = 2 * goal - dr + dl; v2 = rs - ls; side = dr + dl;
        end else begin
          e2 = 2 * goal - dr - dl; v2 = rs + ls; side = dr - dl;
        end
        b = (e2 < 0) ? -bias_cnt : bias_cnt;
        s = (e2 + 2 * b) * longint'(cfg.prop_gain) - v2 * longint'(cfg.deriv_gain);
        a = 2 * side * longint'(cfg.side_gain);
        if (cfg.turn_mode) begin
          want.right_power = POWER_W'(clamp_power(s - a));
          want.left_power  = POWER_W'(clamp_power(a - s));
        end else begin
          want.right_power = POWER_W'(clamp_power(s + a));
          want.left_power  = POWER_W'(clamp_power(s - a));
        end
        ae2 = (e2 < 0) ? -e2 : e2;
        in_thr = ae2 <= 2 * longint'(cfg.settle_threshold);
        if (in_thr && !settle_on) begin
          settle_on = 1; settle_t0 = it.stamp;
        end
        if (!in_thr) settle_on = 0;
        ars = (rs < 0) ? -rs : rs;
        als = (ls < 0) ? -ls : ls;
        if (ars < STALL_SPD && als < STALL_SPD && !stall_on) begin
          stall_on = 1; stall_t0 = it.stamp;
        end
        if (ars > STALL_SPD || als > STALL_SPD) stall_on = 0;
        reached = settle_on &&
                  ((it.stamp - settle_t0) > 32'(SETTLE_MS) || cfg.accept_without_dwell);
        stalled = stall_on && (it.stamp - stall_t0) > 32'(STALL_MS);
        timed   = (cfg.timeout_ms != 0) && (it.stamp - move_t0) > {16'd0, cfg.timeout_ms};
        if (stalled) stall_hit = 1;
        if (timed) tmo_hit = 1;
        want.cause = stalled ? CAUSE_STALLED : timed ? CAUSE_TIMEOUT :
                     reached ? CAUSE_REACHED : CAUSE_RUNNING;
        want.done  = (want.cause != CAUSE_RUNNING);
      end
      expected_results.push_back(want);
    endfunction

    function void check_transaction(drive_result_t got);
      drive_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no transaction pending");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.right_power !== want.right_power) begin
        $error("right_power expected %0d got %0d", want.right_power, got.right_power);
        errors++;
      end
      if (got.left_power !== want.left_power) begin
        $error("left_power expected %0d got %0d", want.left_power, got.left_power);
        errors++;
      end
      if (got.done !== want.done) begin
        $error("move_done expected %0d got %0d", want.done, got.done);
        errors++;
      end
      if (got.cause !== want.cause) begin
        $error("exit_cause expected %0d got %0d", want.cause, got.cause);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_kind = KIND_START;
  logic [TIME_W-1:0]          in_time_ms = '0;
  logic signed [POS_W-1:0]    in_right_position = '0;
  logic signed [POS_W-1:0]    in_left_position = '0;
  logic signed [SPEED_W-1:0]  in_right_speed = '0;
  logic signed [SPEED_W-1:0]  in_left_speed = '0;
  logic signed [TARGET_W-1:0] in_target_distance = '0;
  logic signed [BIAS_W-1:0]   in_overshoot_bias = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [POWER_W-1:0]  out_right_power;
  logic signed [POWER_W-1:0]  out_left_power;
  logic                       out_move_done;
  logic [1:0]                 out_exit_cause;

  drive_move_scoreboard sb = new();
  bit                   tx_steady = 1'b0;
  bit                   rx_steady = 1'b0;
  logic [31:0]          clock_ms = 32'd0;
  int                   cycles = 0;

  differential_drive_pd_move_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_time_ms(in_time_ms),
    .in_right_position(in_right_position), .in_left_position(in_left_position),
    .in_right_speed(in_right_speed), .in_left_speed(in_left_speed),
    .in_target_distance(in_target_distance), .in_overshoot_bias(in_overshoot_bias),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_right_power(out_right_power), .out_left_power(out_left_power),
    .out_move_done(out_move_done), .out_exit_cause(out_exit_cause)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint rand_s(int w);
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    return v >>> (64 - w);
  endfunction

  function automatic longint srand(longint m);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  function automatic drive_item_t make_start(logic [31:0] stamp, longint rp, longint lp,
                                             longint tgt, longint bias);
    drive_item_t it;
    it.kind = KIND_START; it.stamp = stamp;
    it.right_pos = POS_W'(rp); it.left_pos = POS_W'(lp);
    it.right_spd = SPEED_W'(rand_s(SPEED_W)); it.left_spd = SPEED_W'(rand_s(SPEED_W));
    it.target = TARGET_W'(tgt); it.bias = BIAS_W'(bias);
    return it;
  endfunction

  function automatic drive_item_t make_sample(logic [31:0] stamp, longint rp, longint lp,
                                              longint rs, longint ls);
    drive_item_t it;
    it.kind = KIND_SAMPLE; it.stamp = stamp;
    it.right_pos = POS_W'(rp); it.left_pos = POS_W'(lp);
    it.right_spd = SPEED_W'(rs); it.left_spd = SPEED_W'(ls);
    it.target = TARGET_W'(rand_s(TARGET_W)); it.bias = BIAS_W'(rand_s(BIAS_W));
    return it;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 131072));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.turn_mode = 1'($urandom_range(0, 1));
    c.accept_without_dwell = 1'($urandom_range(0, 1));
    c.prop_gain = rand_gain();
    c.deriv_gain = rand_gain();
    c.side_gain = rand_gain();
    case ($urandom_range(0, 3))
      0: c.max_speed = 8'd0;
      1: c.max_speed = 8'd255;
      default: c.max_speed = MAXSPD_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: c.settle_threshold = 16'd0;
      1: c.settle_threshold = 16'hFFFF;
      2: c.settle_threshold = THR_W'($urandom);
      default: c.settle_threshold = THR_W'($urandom_range(0, 200));
    endcase
    case ($urandom_range(0, 4))
      0, 1: c.timeout_ms = 16'd0;
      2: c.timeout_ms = 16'hFFFF;
      3: c.timeout_ms = TMO_W'($urandom_range(1, 60));
      default: c.timeout_ms = TMO_W'($urandom_range(200, 3000));
    endcase
    return c;
  endfunction

  // Leave in_valid high across back-to-back transactions.
  task automatic send(input drive_item_t it);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_kind            <= it.kind;
    in_time_ms         <= it.stamp;
    in_right_position  <= it.right_pos;
    in_left_position   <= it.left_pos;
    in_right_speed     <= it.right_spd;
    in_left_speed      <= it.left_spd;
    in_target_distance <= it.target;
    in_overshoot_bias  <= it.bias;
    do @(posedge clk); while (!in_ready);
    sb.note_transaction(it);
  endtask

  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (sb.pending() != 0 && n < DRAIN_LIMIT);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    put_reg(REG_TURN_MODE, CFG_DATA_W'(c.turn_mode));
    put_reg(REG_ACCEPT_WITHOUT_DWELL, CFG_DATA_W'(c.accept_without_dwell));
    put_reg(REG_PROP_GAIN, c.prop_gain);
    put_reg(REG_DERIV_GAIN, c.deriv_gain);
    put_reg(REG_SIDE_GAIN, c.side_gain);
    put_reg(REG_MAX_SPEED, CFG_DATA_W'(c.max_speed));
    put_reg(REG_SETTLE_THRESHOLD, CFG_DATA_W'(c.settle_threshold));
    put_reg(REG_TIMEOUT_MS, CFG_DATA_W'(c.timeout_ms));
    cfg_we <= 1'b0;
    sb.cfg = c;
    @(posedge clk);
  endtask

  task automatic noise_item();
    drive_item_t it;
    it.kind = 1'($urandom_range(0, 1));
    it.stamp = $urandom;
    it.right_pos = POS_W'(rand_s(POS_W)); it.left_pos = POS_W'(rand_s(POS_W));
    it.right_spd = SPEED_W'(rand_s(SPEED_W)); it.left_spd = SPEED_W'(rand_s(SPEED_W));
    it.target = TARGET_W'(rand_s(TARGET_W)); it.bias = BIAS_W'(rand_s(BIAS_W));
    send(it);
  endtask

  // One move: a start, then samples that mostly hover around the target.
  task automatic random_move(output int used);
    longint org_r, org_l, tgt, bias, jr, j1, j2, rs, ls, far;
    int     nsamp, pick, spd_style;
    logic   turn;
    turn  = sb.cfg.turn_mode;
    org_r = $urandom_range(0, 1) ? srand(1000) : rand_s(POS_W);
    org_l = $urandom_range(0, 1) ? srand(1000) : rand_s(POS_W);
    pick  = $urandom_range(0, 9);
    tgt   = (pick < 6) ? srand(2000) : (pick < 8) ? srand(50) : rand_s(TARGET_W);
    bias  = $urandom_range(0, 1) ? srand(100) : rand_s(BIAS_W);
    if ($urandom_range(0, 15) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 600);
    send(make_start(clock_ms, org_r, org_l, tgt, bias));
    spd_style = $urandom_range(0, 2);
    nsamp = $urandom_range(3, 30);
    for (int i = 0; i < nsamp; i++) begin
      pick = $urandom_range(0, 9);
      clock_ms += (pick < 7) ? $urandom_range(0, 40) :
                  (pick < 9) ? $urandom_range(100, 400) : $urandom_range(900, 1200);
      jr   = longint'(sb.cfg.settle_threshold) + $urandom_range(0, 1);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        j1 = srand(jr); j2 = srand(jr);
      end else if (pick < 9) begin
        far = ((tgt < 0) ? -tgt : tgt) + 5000;
        j1 = srand(far); j2 = srand(far);
      end else begin
        j1 = rand_s(POS_W); j2 = rand_s(POS_W);
      end
      case (spd_style)
        0: begin
          rs = srand(STALL_SPD + 2); ls = srand(STALL_SPD + 2);
        end
        1: begin
          rs = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? STALL_SPD : -STALL_SPD)
                                    : srand(STALL_SPD + 1);
          ls = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? STALL_SPD : -STALL_SPD)
                                    : srand(STALL_SPD + 1);
        end
        default: begin
          rs = rand_s(SPEED_W); ls = rand_s(SPEED_W);
        end
      endcase
      send(make_sample(clock_ms, org_r + tgt + j1,
                       org_l + (turn ? -tgt : tgt) + j2, rs, ls));
    end
    used = nsamp + 1;
  endtask

  task automatic run_phase(input cfg_t c, input int items);
    int sent, used;
    apply_config(c);
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) begin
        noise_item();
        sent++;
      end else begin
        random_move(used);
        sent += used;
      end
    end
    drain();
  endtask

  // Receiver: random stall per result, check each accepted transaction.
  initial begin
    int            stall;
    drive_result_t got;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.right_power = out_right_power;
      got.left_power  = out_left_power;
      got.done        = out_move_done;
      got.cause       = exit_cause_t'(out_exit_cause);
      sb.check_transaction(got);
    end
  end

  initial begin
    cfg_t c;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: sample before any start, extremes, dwell and stall edges.
    send(make_sample(32'd5, 8388607, -8388608, -1024, 1023));
    send(make_start(32'd1000, -8388608, 8388607, 8388607, -32768));
    send(make_sample(32'd1010, 8388607, -8388608, 1023, -1024));
    send(make_start(32'd2000, 0, 0, 0, 32767));
    send(make_sample(32'd2000, 0, 0, 60, -60));
    send(make_sample(32'd2250, 0, 0, 60, 60));
    send(make_sample(32'd2251, 0, 0, 60, 60));
    send(make_sample(32'd2260, 100, 100, 60, 60));
    send(make_start(32'd5000, 10, 20, 300, 0));
    send(make_sample(32'd5000, 10, 20, 0, 0));
    send(make_sample(32'd5600, 10, 20, 50, -50));
    send(make_sample(32'd6000, 10, 20, 3, 4));
    send(make_sample(32'd6001, 10, 20, 3, 4));
    send(make_sample(32'd6100, 10, 20, 51, 51));
    send(make_start(32'hFFFF_FF80, 0, 0, 5, 0));
    send(make_sample(32'hFFFF_FFF0, 5, 5, 200, 200));
    send(make_sample(32'h0000_0100, 5, 5, 200, 200));
    drain();

    // Maximum gains and clamp, zero threshold, short timeout, turn in place.
    c = '{turn_mode: 1'b1, accept_without_dwell: 1'b1, prop_gain: '1, deriv_gain: '1,
          side_gain: '1, max_speed: 8'd255, settle_threshold: 16'd0, timeout_ms: 16'd100};
    apply_config(c);
    send(make_start(32'd100, 0, 0, -8388608, 32767));
    send(make_sample(32'd150, 500, -500, 1023, -1024));
    send(make_start(32'd300, 0, 0, 10, -5));
    send(make_sample(32'd300, 10, -10, 200, 200));
    send(make_sample(32'd401, 12, -9, 200, 200));
    send(make_sample(32'd402, 12, -9, 200, 200));
    send(make_start(32'd1000, 0, 0, 40, 0));
    send(make_sample(32'd1000, 3, 3, 0, 0));
    send(make_sample(32'd2001, 3, 3, 0, 0));
    send(make_sample(32'd2005, 3, 3, 0, 0));
    drain();

    c = '{turn_mode: 1'b0, accept_without_dwell: 1'b0, prop_gain: '0, deriv_gain: '0,
          side_gain: '0, max_speed: 8'd0, settle_threshold: 16'hFFFF, timeout_ms: 16'hFFFF};
    run_phase(c, 130);
    run_phase(CFG_RESET, 140);
    for (int p = 0; p < 6; p++) run_phase(rand_cfg(), 140);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/ddpm_pkg.sv
hw/rtl/ddpm_queue.sv
hw/rtl/ddpm_front.sv
hw/rtl/ddpm_back.sv
hw/rtl/differential_drive_pd_move_unit.sv
tb/sv/testbench.sv
